[design/assert_macros.svh]
// Assertion macros used by the RTL file arrival_horizon_histogram.sv.
// Uses the i_clk / i_rst_n names of the module that includes it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain invariant, checked at every clock edge outside reset.
`define AHH_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define AHH_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define AHH_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/ahh_pkg.sv]
// Package for the arrival horizon histogram: item types, table entry and
// bin count layouts, codes and default sizes. No dependencies.
package ahh_pkg;

    localparam int HORIZON_BINS_DEF = 64;
    localparam int PHASES_DEF       = 3;
    localparam int TABLE_DEPTH_DEF  = 64;

    localparam logic [11:0] DIST_RESET = 12'd700;

    // numerator is dist*1024 + speed, 23 bits wide
    localparam int NUM_W     = 23;
    localparam int DIV_W     = 17;
    localparam int DIV_STEPS = NUM_W;

    localparam logic        MODE_DETECT = 1'b0;
    localparam logic        MODE_TICK   = 1'b1;

    localparam logic [1:0]  PHASE_A = 2'd0;
    localparam logic [1:0]  PHASE_B = 2'd1;
    localparam logic [1:0]  PHASE_C = 2'd2;

    localparam logic [6:0]  CNT_MAX  = 7'd127;
    localparam logic [23:0] TIME_MAX = 24'hFFFFFF;

    typedef struct packed {
        logic        mode;
        logic [23:0] now_time;
        logic [15:0] speed;
        logic [1:0]  phase;
    } t_in_item;

    typedef struct packed {
        logic [5:0] bin_index;
        logic [6:0] count_phase_a;
        logic [6:0] count_phase_b;
        logic [6:0] count_phase_c;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic [23:0] arr_time;
        logic [1:0]  arr_phase;
    } t_entry;

    typedef struct packed {
        logic [6:0] cnt_a;
        logic [6:0] cnt_b;
        logic [6:0] cnt_c;
    } t_bin_cnt;

endpackage

[design/arrival_horizon_histogram.sv]
// Arrival horizon histogram, top level.
// Depends on ahh_pkg and assert_macros.svh.
`include "assert_macros.svh"

// Predicted arrivals sit in a compacted table memory (entries 0..fill-1 are
// live); per-bin counts sit in a second memory. A detection is dropped
// when it has zero speed, a bad phase or meets a full table; else it runs
// through the bit-serial travel time divider and is then stored. A tick
// walks the live entries through a read/modify/write pipeline on the count
// memory, then reads out each bin, clearing it as it goes; each bin is held
// on the output until the output is ready. Inputs are taken one item at a
// time. After reset the count memory is swept to zero; no item is accepted
// until the sweep ends.
module arrival_horizon_histogram #(
    parameter int HORIZON_BINS = ahh_pkg::HORIZON_BINS_DEF,
    parameter int PHASES       = ahh_pkg::PHASES_DEF,
    parameter int TABLE_DEPTH  = ahh_pkg::TABLE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [11:0]        i_cfg_wr_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ahh_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ahh_pkg::t_out_item o_out_item
);
    import ahh_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int BW = $clog2(HORIZON_BINS);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_DIV, S_STORE, S_WALK, S_EMIT_RD, S_EMIT_WAIT
    } t_state;

    t_state r_state, n_state;

    logic [11:0]      r_dist;
    logic [23:0]      r_now, n_now;
    logic [1:0]       r_phase, n_phase;
    logic [DIV_W-1:0] r_div, n_div;
    logic [DIV_W-1:0] r_rem, n_rem;
    logic [NUM_W-1:0] r_quo, n_quo;
    logic [4:0]       r_step, n_step;
    logic [CW-1:0]    r_fill, n_fill;
    logic [CW-1:0]    r_rd_idx, n_rd_idx;
    logic [CW-1:0]    r_wr_idx, n_wr_idx;
    logic             r_s1_v, n_s1_v;
    logic             r_s2_v, n_s2_v;
    logic [BW-1:0]    r_s2_addr, n_s2_addr;
    logic [1:0]       r_s2_ph, n_s2_ph;
    logic             r_lw_en, n_lw_en;
    logic [BW-1:0]    r_lw_addr, n_lw_addr;
    t_bin_cnt         r_lw_data, n_lw_data;
    logic [BW-1:0]    r_bin, n_bin;
    logic             r_out_valid, n_out_valid;
    logic [5:0]       r_out_bin, n_out_bin;
    logic             r_out_last, n_out_last;

    // table memory and its registered read data
    t_entry           tbl_mem [TABLE_DEPTH];
    t_entry           r_tq;
    logic             tbl_we, tbl_re;
    logic [AW-1:0]    tbl_waddr, tbl_raddr;
    t_entry           tbl_wdata;

    // bin count memory and its registered read data (also output payload)
    t_bin_cnt         bc_mem [HORIZON_BINS];
    t_bin_cnt         r_bq;
    logic             bc_we, bc_re;
    logic [BW-1:0]    bc_waddr, bc_raddr;
    t_bin_cnt         bc_wdata;

    // datapath helpers
    logic [NUM_W-1:0] num;
    logic [DIV_W:0]   trial, diff;
    logic             ge;
    logic [24:0]      arr_sum;
    logic [23:0]      ahead;
    logic             keep, hit;
    t_bin_cnt         base, incr;
    logic             bin_end;

    assign num   = {1'b0, r_dist, 10'd0} + {7'd0, i_in_item.speed};
    assign trial = {r_rem, r_quo[NUM_W-1]};
    assign ge    = trial >= {1'b0, r_div};
    assign diff  = trial - {1'b0, r_div};

    assign arr_sum = {1'b0, r_now} + {2'd0, r_quo};

    assign keep  = r_tq.arr_time >= r_now;
    assign ahead = r_tq.arr_time - r_now;
    assign hit   = keep && (ahead < 24'(HORIZON_BINS)) && (r_tq.arr_phase <= PHASE_C);

    // the write issued in the previous cycle is not yet in r_bq
    assign base = (r_lw_en && r_lw_addr == r_s2_addr) ? r_lw_data : r_bq;

    always_comb begin
        incr = base;
        case (r_s2_ph)
            PHASE_A: if (base.cnt_a != CNT_MAX) incr.cnt_a = base.cnt_a + 7'd1;
            PHASE_B: if (base.cnt_b != CNT_MAX) incr.cnt_b = base.cnt_b + 7'd1;
            PHASE_C: if (base.cnt_c != CNT_MAX) incr.cnt_c = base.cnt_c + 7'd1;
            default: incr = base;
        endcase
    end

    assign bin_end = r_bin == BW'(HORIZON_BINS - 1);

    always_comb begin
        n_state     = r_state;
        n_now       = r_now;
        n_phase     = r_phase;
        n_div       = r_div;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_step      = r_step;
        n_fill      = r_fill;
        n_rd_idx    = r_rd_idx;
        n_wr_idx    = r_wr_idx;
        n_s1_v      = 1'b0;
        n_s2_v      = 1'b0;
        n_s2_addr   = r_s2_addr;
        n_s2_ph     = r_s2_ph;
        n_lw_en     = 1'b0;
        n_lw_addr   = r_lw_addr;
        n_lw_data   = r_lw_data;
        n_bin       = r_bin;
        n_out_valid = r_out_valid;
        n_out_bin   = r_out_bin;
        n_out_last  = r_out_last;

        tbl_we    = 1'b0;
        tbl_waddr = r_wr_idx[AW-1:0];
        tbl_wdata = r_tq;
        tbl_re    = 1'b0;
        tbl_raddr = r_rd_idx[AW-1:0];
        bc_we     = 1'b0;
        bc_waddr  = r_bin;
        bc_wdata  = '0;
        bc_re     = 1'b0;
        bc_raddr  = r_bin;

        case (r_state)
            S_CLEAR: begin
                bc_we = 1'b1;
                if (bin_end) begin
                    n_bin   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_bin = r_bin + BW'(1);
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_now   = i_in_item.now_time;
                    n_phase = i_in_item.phase;
                    if (i_in_item.mode == MODE_TICK) begin
                        n_rd_idx = '0;
                        n_wr_idx = '0;
                        n_state  = S_WALK;
                    end else if (i_in_item.speed != 16'd0
                                 && {6'd0, i_in_item.phase} < 8'(PHASES)
                                 && r_fill != CW'(TABLE_DEPTH)) begin
                        n_div   = {i_in_item.speed, 1'b0};
                        n_rem   = '0;
                        n_quo   = num;
                        n_step  = '0;
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                // restoring division, one quotient bit per cycle
                n_rem  = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
                n_quo  = {r_quo[NUM_W-2:0], ge};
                n_step = r_step + 5'd1;
                if (r_step == 5'(DIV_STEPS - 1)) n_state = S_STORE;
            end
            S_STORE: begin
                tbl_we    = 1'b1;
                tbl_waddr = r_fill[AW-1:0];
                tbl_wdata.arr_time  = arr_sum[24] ? TIME_MAX : arr_sum[23:0];
                tbl_wdata.arr_phase = r_phase;
                n_fill    = r_fill + CW'(1);
                n_state   = S_IDLE;
            end
            S_WALK: begin
                // fetch
                if (r_rd_idx != r_fill) begin
                    tbl_re   = 1'b1;
                    n_rd_idx = r_rd_idx + CW'(1);
                    n_s1_v   = 1'b1;
                end
                // survivors are packed down to r_wr_idx; lookup the bin
                if (r_s1_v) begin
                    if (keep) begin
                        tbl_we   = 1'b1;
                        n_wr_idx = r_wr_idx + CW'(1);
                    end
                    if (hit) begin
                        bc_re     = 1'b1;
                        bc_raddr  = ahead[BW-1:0];
                        n_s2_v    = 1'b1;
                        n_s2_addr = ahead[BW-1:0];
                        n_s2_ph   = r_tq.arr_phase;
                    end
                end
                // count update
                if (r_s2_v) begin
                    bc_we     = 1'b1;
                    bc_waddr  = r_s2_addr;
                    bc_wdata  = incr;
                    n_lw_en   = 1'b1;
                    n_lw_addr = r_s2_addr;
                    n_lw_data = incr;
                end
                if (r_rd_idx == r_fill && !r_s1_v && !r_s2_v) begin
                    n_fill  = r_wr_idx;
                    n_bin   = '0;
                    n_state = S_EMIT_RD;
                end
            end
            S_EMIT_RD: begin
                // read the bin and clear it for the next tick
                bc_re       = 1'b1;
                bc_we       = 1'b1;
                n_out_valid = 1'b1;
                n_out_bin   = 6'(r_bin);
                n_out_last  = bin_end;
                n_state     = S_EMIT_WAIT;
            end
            S_EMIT_WAIT: begin
                if (i_out_ready) begin
                    n_out_valid = 1'b0;
                    if (r_out_last) begin
                        n_bin   = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_bin   = r_bin + BW'(1);
                        n_state = S_EMIT_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (tbl_we) tbl_mem[tbl_waddr] <= tbl_wdata;
        if (tbl_re) r_tq <= tbl_mem[tbl_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (bc_we) bc_mem[bc_waddr] <= bc_wdata;
        if (bc_re) r_bq <= bc_mem[bc_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_dist      <= DIST_RESET;
            r_fill      <= '0;
            r_rd_idx    <= '0;
            r_wr_idx    <= '0;
            r_s1_v      <= 1'b0;
            r_s2_v      <= 1'b0;
            r_lw_en     <= 1'b0;
            r_bin       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            if (i_cfg_wr_en) r_dist <= i_cfg_wr_data;
            r_fill      <= n_fill;
            r_rd_idx    <= n_rd_idx;
            r_wr_idx    <= n_wr_idx;
            r_s1_v      <= n_s1_v;
            r_s2_v      <= n_s2_v;
            r_lw_en     <= n_lw_en;
            r_bin       <= n_bin;
            r_out_valid <= n_out_valid;
        end
        r_now      <= n_now;
        r_phase    <= n_phase;
        r_div      <= n_div;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_step     <= n_step;
        r_s2_addr  <= n_s2_addr;
        r_s2_ph    <= n_s2_ph;
        r_lw_addr  <= n_lw_addr;
        r_lw_data  <= n_lw_data;
        r_out_bin  <= n_out_bin;
        r_out_last <= n_out_last;
    end

    assign o_in_ready = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out_item.bin_index     = r_out_bin;
    assign o_out_item.count_phase_a = r_bq.cnt_a;
    assign o_out_item.count_phase_b = r_bq.cnt_b;
    assign o_out_item.count_phase_c = r_bq.cnt_c;
    assign o_out_item.last          = r_out_last;

    `AHH_ASSERT(a_fill_bound, r_fill <= CW'(TABLE_DEPTH), "fill count past table depth")
    `AHH_ASSERT_IMP(a_pack_order, r_state == S_WALK, r_wr_idx <= r_rd_idx,
        "compaction pointer ran ahead of fetch pointer")
    `AHH_ASSERT_IMP(a_ready_no_out, o_in_ready, !o_out_valid,
        "input taken while a result is pending")
    `AHH_ASSERT_NXT(a_last_to_idle, o_out_valid && i_out_ready && o_out_item.last,
        o_in_ready, "block not idle after final bin")

endmodule

[dv/arrival_horizon_histogram_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for arrival_horizon_histogram: drives detection and tick
// items over valid/ready and checks every horizon bin against its own arrival table.
// Depends on ahh_pkg and the arrival_horizon_histogram RTL.

// Tracks the predicted arrival table and the histogram bins each tick should produce.
class arrival_ledger;
    bit                   slot_live  [ahh_pkg::TABLE_DEPTH_DEF];
    logic [23:0]          slot_time  [ahh_pkg::TABLE_DEPTH_DEF];
    logic [1:0]           slot_phase [ahh_pkg::TABLE_DEPTH_DEF];
    logic [11:0]          distance = ahh_pkg::DIST_RESET;
    ahh_pkg::t_out_item   due_bins [$];
    int                   errors, bins_seen, detections, dropped, ticks;

    function void note_item(ahh_pkg::t_in_item it);
        logic [6:0]  tally [ahh_pkg::HORIZON_BINS_DEF][3];
        logic [23:0] numer, steps, ahead;
        logic [24:0] sum;
        ahh_pkg::t_out_item bin;
        int k, free;
        if (it.mode == ahh_pkg::MODE_DETECT) begin
            detections++;
            free = -1;
            for (k = ahh_pkg::TABLE_DEPTH_DEF - 1; k >= 0; k--)
                if (!slot_live[k]) free = k;
            if (it.speed == '0 || it.phase > ahh_pkg::PHASE_C || free < 0) begin
                dropped++;
                return;
            end
            // distance*512/speed rounded half up, in half-second steps
            numer = {2'b00, distance, 10'd0} + {8'd0, it.speed};
            steps = numer / {7'd0, it.speed, 1'b0};
            sum = {1'b0, it.now_time} + {1'b0, steps};
            slot_live[free]  = 1'b1;
            slot_time[free]  = sum[24] ? ahh_pkg::TIME_MAX : sum[23:0];
            slot_phase[free] = it.phase;
            return;
        end
        ticks++;
        foreach (tally[b, p]) tally[b][p] = '0;
        for (k = 0; k < ahh_pkg::TABLE_DEPTH_DEF; k++) begin
            if (!slot_live[k]) continue;
            if (slot_time[k] < it.now_time) begin
                slot_live[k] = 1'b0;
                continue;
            end
            ahead = slot_time[k] - it.now_time;
            if (ahead < 24'(ahh_pkg::HORIZON_BINS_DEF)
                && tally[ahead][slot_phase[k]] != ahh_pkg::CNT_MAX)
                tally[ahead][slot_phase[k]]++;
        end
        for (k = 0; k < ahh_pkg::HORIZON_BINS_DEF; k++) begin
            bin.bin_index     = 6'(k);
            bin.count_phase_a = tally[k][0];
            bin.count_phase_b = tally[k][1];
            bin.count_phase_c = tally[k][2];
            bin.last          = (k == ahh_pkg::HORIZON_BINS_DEF - 1);
            due_bins.insert(due_bins.size(), bin);
        end
    endfunction

    task report_mismatch(string what);
        errors++;
        $display("arrival_horizon_histogram_test: mismatch: %s", what);
    endtask

    task check_bin(ahh_pkg::t_out_item got);
        ahh_pkg::t_out_item want;
        bins_seen++;
        if (due_bins.size() == 0) begin
            report_mismatch($sformatf("bin %0d arrived with nothing pending", got.bin_index));
            return;
        end
        want = due_bins.pop_front();
        if (got.bin_index !== want.bin_index)
            report_mismatch($sformatf("bin_index got %0d want %0d",
                                      got.bin_index, want.bin_index));
        if (got.count_phase_a !== want.count_phase_a)
            report_mismatch($sformatf("bin %0d count_phase_a got %0d want %0d",
                                      want.bin_index, got.count_phase_a, want.count_phase_a));
        if (got.count_phase_b !== want.count_phase_b)
            report_mismatch($sformatf("bin %0d count_phase_b got %0d want %0d",
                                      want.bin_index, got.count_phase_b, want.count_phase_b));
        if (got.count_phase_c !== want.count_phase_c)
            report_mismatch($sformatf("bin %0d count_phase_c got %0d want %0d",
                                      want.bin_index, got.count_phase_c, want.count_phase_c));
        if (got.last !== want.last)
            report_mismatch($sformatf("bin %0d last got %0b want %0b",
                                      want.bin_index, got.last, want.last));
    endtask
endclass

module arrival_horizon_histogram_test;
    import ahh_pkg::*;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int DRAIN_CYCLES = 64;   // covers a detection's divide and a tick's tail
    localparam int SETTLE_CYCLES = 200;
    localparam int PHASE_ITEMS = 40;
    localparam int FILL_ITEMS = 70;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [11:0] i_cfg_wr_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_item = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_item;

    arrival_ledger ledger = new;
    logic [23:0]   sim_now = 24'd1000;
    bit            steady = 1'b0;
    int            cycles = 0;
    int            settings = 1;

    arrival_horizon_histogram dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_item     (i_in_item),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_item    (o_out_item)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("arrival_horizon_histogram_test: timed out after %0d cycles", cycles);
            $display("arrival_horizon_histogram_test: done, errors");
            $finish;
        end
    end

    function automatic int draw_gap();
        return steady ? 0 : $urandom_range(0, 6);
    endfunction

    function automatic t_in_item make_item(logic mode, logic [23:0] at, logic [15:0] spd,
                                           logic [1:0] ph);
        t_in_item it;
        it.mode = mode;
        it.now_time = at;
        it.speed = spd;
        it.phase = ph;
        return it;
    endfunction

    // Detection whose speed puts the arrival roughly target steps ahead.
    function automatic t_in_item arrival_toward(logic [23:0] at, int target);
        int spd;
        spd = (int'(ledger.distance) * 1024) / (2 * target + 1);
        if (spd == 0 || spd > 65535) spd = $urandom_range(1, 65535);
        return make_item(MODE_DETECT, at, 16'(spd), 2'($urandom_range(0, 2)));
    endfunction

    task automatic send_item(t_in_item it);
        int gap;
        gap = draw_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        ledger.note_item(it);
    endtask

    task automatic quiesce();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (ledger.due_bins.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_distance(logic [11:0] value);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        ledger.distance = value;
        settings++;
    endtask

    task automatic run_directed();
        // ties round up: 87.5 -> 88 and 17.5 -> 18 steps at distance 700
        send_item(make_item(MODE_DETECT, 24'd100, 16'd4096, PHASE_A));
        send_item(make_item(MODE_DETECT, 24'd100, 16'd20480, PHASE_B));
        send_item(make_item(MODE_DETECT, 24'd100, 16'hFFFF, PHASE_C));
        send_item(make_item(MODE_DETECT, 24'd100, 16'd0, PHASE_A));
        send_item(make_item(MODE_DETECT, 24'd100, 16'd4096, 2'd3));
        send_item(make_item(MODE_DETECT, 24'd0, 16'd20480, PHASE_A));
        send_item(make_item(MODE_TICK, 24'd100, 16'hFFFF, 2'd3));
        send_item(make_item(MODE_TICK, 24'd130, 16'd0, PHASE_A));
        send_item(make_item(MODE_TICK, 24'd188, 16'd0, PHASE_A));
        send_item(make_item(MODE_TICK, 24'd189, 16'd0, PHASE_A));
        // arrival time saturates at the top of the time range
        send_item(make_item(MODE_DETECT, 24'hFFFFF5, 16'd1, PHASE_B));
        send_item(make_item(MODE_DETECT, TIME_MAX, 16'hFFFF, PHASE_C));
        send_item(make_item(MODE_DETECT, 24'hFFFFC0, 16'd4096, PHASE_A));
        send_item(make_item(MODE_TICK, 24'hFFFFC0, 16'd0, PHASE_A));
        send_item(make_item(MODE_TICK, TIME_MAX, 16'd0, PHASE_A));
        send_item(make_item(MODE_TICK, 24'd0, 16'd0, PHASE_A));
    endtask

    task automatic run_random(int count, bit with_fill);
        t_in_item it;
        int n, k, pick;
        for (n = 0; n < count; n++) begin
            if (n % 20 == 0) steady = ($urandom_range(0, 3) == 0);
            if (with_fill && n == count / 2) begin
                // burst of arrivals to run the table full
                for (k = 0; k < FILL_ITEMS; k++)
                    send_item(arrival_toward(sim_now, $urandom_range(20, 63)));
            end
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                it = make_item(1'($urandom_range(0, 1)), 24'($urandom), 16'($urandom),
                               2'($urandom));
                if ($urandom_range(0, 3) == 0) it.speed = '0;
            end else if (pick < 38) begin
                sim_now = sim_now + 24'($urandom_range(0, 12));
                it = make_item(MODE_TICK, sim_now, 16'($urandom), 2'($urandom));
            end else begin
                it = arrival_toward(sim_now, $urandom_range(0, 90));
            end
            send_item(it);
        end
    endtask

    // result side: random stall before each item
    initial begin
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                @(negedge i_clk);
                i_out_ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (o_out_valid !== 1'b1) @(posedge i_clk);
            ledger.check_bin(o_out_item);
        end
    end

    initial begin
        logic [11:0] plan [6];
        int ph;
        plan = '{DIST_RESET, 12'd4095, 12'd1, 12'd0, 12'($urandom_range(2, 4094)), DIST_RESET};
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        for (ph = 0; ph < 6; ph++) begin
            if (ph > 0) begin
                quiesce();
                write_distance(plan[ph]);
            end
            run_random(PHASE_ITEMS, ph == 2);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (ledger.due_bins.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("arrival_horizon_histogram_test: %0d detections (%0d dropped), %0d ticks,",
                 ledger.detections, ledger.dropped, ledger.ticks);
        $display("arrival_horizon_histogram_test: %0d bins checked over %0d distance settings",
                 ledger.bins_seen, settings);
        if (ledger.errors == 0) begin
            $display("arrival_horizon_histogram_test: done, clean");
        end else begin
            $display("arrival_horizon_histogram_test: done, errors");
        end
        $finish;
    end
endmodule

[filelist.f]
+incdir+design
design/ahh_pkg.sv
design/arrival_horizon_histogram.sv
dv/arrival_horizon_histogram_test.sv
